// ===== design/mwm_pkg.sv =====
// Shared types, constants and cell helpers for the maze wall map.
package mwm_pkg;

  localparam int MAZE_WIDTH  = 16;
  localparam int MAZE_HEIGHT = 16;
  localparam int POS_W       = 4;
  localparam int HEAD_W      = 4;
  localparam int OP_W        = 2;
  localparam int SIDE_W      = 2;
  localparam int CELL_BITS   = 4 * SIDE_W;
  localparam int MAP_DEPTH   = MAZE_WIDTH * MAZE_HEIGHT;
  localparam int ADDR_W      = $clog2(MAP_DEPTH);

  localparam logic [SIDE_W-1:0] UNKNOWN = 2'd0;
  localparam logic [SIDE_W-1:0] NOWALL  = 2'd1;
  localparam logic [SIDE_W-1:0] WALL    = 2'd2;
  localparam logic [SIDE_W-1:0] VWALL   = 2'd3;

  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
  localparam logic [OP_W-1:0] OP_RECORD = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

  typedef enum logic [1:0] {DIR_N, DIR_E, DIR_S, DIR_W} dir_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MERGE, ST_NB_N, ST_NB_E, ST_NB_S, ST_NB_W, ST_QUERY, ST_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic clear;
    logic rd_center;
    dir_t rd_dir;
    logic wr_center;
    logic wr_nb;
    dir_t wr_dir;
    logic query;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic do_clear;
    logic do_record;
    logic do_query;
    logic out_free;
  } status_t;

  function automatic logic [ADDR_W-1:0] cell_of(input logic [POS_W-1:0] x,
                                               input logic [POS_W-1:0] y);
    return ADDR_W'(int'(y) * MAZE_WIDTH + int'(x));
  endfunction

  function automatic logic [SIDE_W-1:0] get_side(input logic [CELL_BITS-1:0] c,
                                                input dir_t dir);
    return c[SIDE_W*int'(dir) +: SIDE_W];
  endfunction

  function automatic logic [CELL_BITS-1:0] put_side(input logic [CELL_BITS-1:0] c,
                                                   input dir_t dir,
                                                   input logic [SIDE_W-1:0] v);
    logic [CELL_BITS-1:0] r;
    r = c;
    r[SIDE_W*int'(dir) +: SIDE_W] = v;
    return r;
  endfunction

  function automatic logic [CELL_BITS-1:0] border_cell(input logic [POS_W-1:0] x,
                                                      input logic [POS_W-1:0] y);
    logic [CELL_BITS-1:0] c;
    c = '0;
    if (y == '0) c = put_side(c, DIR_S, WALL);
    if (int'(y) == MAZE_HEIGHT - 1) c = put_side(c, DIR_N, WALL);
    if (x == '0) c = put_side(c, DIR_W, WALL);
    if (int'(x) == MAZE_WIDTH - 1) c = put_side(c, DIR_E, WALL);
    if (x == POS_W'(0) && y == '0) c = put_side(c, DIR_E, WALL);
    if (x == POS_W'(1) && y == '0) c = put_side(c, DIR_W, WALL);
    return c;
  endfunction

endpackage

// ===== design/mwm_ctrl.sv =====
// Sequencer for clear, record and query transactions of the wall map.
module mwm_ctrl import mwm_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_stall,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    item_stall = 1'b1;
    case (state)
      ST_IDLE: begin
        item_stall = 1'b0;
        cmd.rd_center = 1'b1;
        if (item_valid) begin
          cmd.load = 1'b1;
          cmd.clear = status.do_clear;
          if (status.do_record) begin
            state_next = ST_MERGE;
          end else if (status.do_query) begin
            state_next = ST_QUERY;
          end else begin
            state_next = ST_FINISH;
          end
        end
      end
      ST_MERGE: begin
        cmd.wr_center = 1'b1;
        cmd.rd_dir = DIR_N;
        state_next = ST_NB_N;
      end
      ST_NB_N: begin
        cmd.wr_nb = 1'b1;
        cmd.wr_dir = DIR_N;
        cmd.rd_dir = DIR_E;
        state_next = ST_NB_E;
      end
      ST_NB_E: begin
        cmd.wr_nb = 1'b1;
        cmd.wr_dir = DIR_E;
        cmd.rd_dir = DIR_S;
        state_next = ST_NB_S;
      end
      ST_NB_S: begin
        cmd.wr_nb = 1'b1;
        cmd.wr_dir = DIR_S;
        cmd.rd_dir = DIR_W;
        state_next = ST_NB_W;
      end
      ST_NB_W: begin
        cmd.wr_nb = 1'b1;
        cmd.wr_dir = DIR_W;
        state_next = ST_FINISH;
      end
      ST_QUERY: begin
        cmd.query = 1'b1;
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  a_stall_outside_idle: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> item_stall)
    else $error("input taken while a transaction is in flight");

  a_merge_walks_nb: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MERGE) |=> ##3 (state == ST_NB_W))
    else $error("neighbor sweep skipped a step");

  a_record_from_accept: assert property (@(posedge clk) disable iff (rst)
    (cmd.load && status.do_record) |=> (state == ST_MERGE))
    else $error("record transaction did not start merge");

endmodule

// ===== design/mwm_datapath.sv =====
// Wall map memory, valid bits, merge logic and result register.
module mwm_datapath import mwm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  cmd_t              cmd,
  output status_t           status,
  input  logic [OP_W-1:0]   operation,
  input  logic [POS_W-1:0]  pos_x,
  input  logic [POS_W-1:0]  pos_y,
  input  logic [HEAD_W-1:0] heading,
  input  logic              front_right_wall,
  input  logic              front_left_wall,
  input  logic              side_right_wall,
  input  logic              side_left_wall,
  output logic              result_valid,
  input  logic              result_stall,
  output logic [SIDE_W-1:0] side_state,
  output logic              cell_unexplored
);

  logic [CELL_BITS-1:0] map_mem [MAP_DEPTH];
  logic [MAP_DEPTH-1:0] map_valid;

  logic [POS_W-1:0]     cur_x;
  logic [POS_W-1:0]     cur_y;
  logic [HEAD_W-1:0]    cur_head;
  logic                 cur_front;
  logic                 cur_right;
  logic                 cur_left;

  logic [CELL_BITS-1:0] map_data;
  logic                 map_hit;
  logic [CELL_BITS-1:0] last_def;
  logic [ADDR_W-1:0]    last_addr;
  logic                 last_ok;
  logic [CELL_BITS-1:0] merged;
  logic [SIDE_W-1:0]    res_side;
  logic                 res_unexp;

  logic                 in_maze;
  logic [POS_W-1:0]     rd_x;
  logic [POS_W-1:0]     rd_y;
  logic                 rd_ok;
  logic [ADDR_W-1:0]    rd_addr;
  logic [CELL_BITS-1:0] eff;
  logic [CELL_BITS-1:0] merged_c;
  logic [SIDE_W-1:0]    reading;
  logic [SIDE_W-1:0]    old_side;
  logic                 wr_en;
  logic [CELL_BITS-1:0] wr_data;
  dir_t                 rel;
  dir_t                 face;

  assign in_maze = (int'(pos_x) < MAZE_WIDTH) && (int'(pos_y) < MAZE_HEIGHT);
  assign status.do_clear  = (operation == OP_CLEAR);
  assign status.do_record = (operation == OP_RECORD) && in_maze && (heading[3:2] == 2'b00);
  assign status.do_query  = (operation == OP_QUERY) && in_maze;
  assign status.out_free  = !result_valid || !result_stall;

  always_comb begin
    rd_x = cur_x;
    rd_y = cur_y;
    rd_ok = 1'b1;
    if (cmd.rd_center) begin
      rd_x = pos_x;
      rd_y = pos_y;
    end else begin
      case (cmd.rd_dir)
        DIR_N: begin
          rd_y = cur_y + POS_W'(1);
          rd_ok = (int'(cur_y) + 1) < MAZE_HEIGHT;
        end
        DIR_E: begin
          rd_x = cur_x + POS_W'(1);
          rd_ok = (int'(cur_x) + 1) < MAZE_WIDTH;
        end
        DIR_S: begin
          rd_y = cur_y - POS_W'(1);
          rd_ok = (cur_y != '0);
        end
        DIR_W: begin
          rd_x = cur_x - POS_W'(1);
          rd_ok = (cur_x != '0);
        end
        default: begin
          rd_ok = 1'b0;
        end
      endcase
    end
    rd_addr = cell_of(rd_x, rd_y);
  end

  assign eff = map_hit ? map_data : last_def;

  always_comb begin
    merged_c = eff;
    for (int k = 0; k < 4; k++) begin
      rel = dir_t'(2'(k) - cur_head[1:0]);
      case (rel)
        DIR_N:   reading = (cur_front) ? WALL : NOWALL;
        DIR_E:   reading = (cur_right) ? WALL : NOWALL;
        DIR_S:   reading = NOWALL;
        DIR_W:   reading = (cur_left) ? WALL : NOWALL;
        default: reading = NOWALL;
      endcase
      old_side = get_side(eff, dir_t'(k));
      merged_c = put_side(merged_c, dir_t'(k),
                          (old_side == UNKNOWN || old_side == reading) ? reading : VWALL);
    end
  end

  always_comb begin
    face = dir_t'(cmd.wr_dir ^ 2'b10);
    wr_en = cmd.wr_center || (cmd.wr_nb && last_ok);
    wr_data = cmd.wr_center ? merged_c : put_side(eff, face, get_side(merged, cmd.wr_dir));
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      map_mem[last_addr] <= wr_data;
    end
    map_data <= map_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      map_valid <= '0;
      map_hit <= 1'b0;
    end else begin
      map_hit <= map_valid[rd_addr];
      if (cmd.clear) begin
        map_valid <= '0;
      end else if (wr_en) begin
        map_valid[last_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    last_addr <= rd_addr;
    last_ok <= rd_ok;
    last_def <= border_cell(rd_x, rd_y);
    if (cmd.load) begin
      cur_x <= pos_x;
      cur_y <= pos_y;
      cur_head <= heading;
      cur_front <= front_right_wall | front_left_wall;
      cur_right <= side_right_wall;
      cur_left <= side_left_wall;
    end
    if (cmd.wr_center) begin
      merged <= merged_c;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res_side <= UNKNOWN;
      res_unexp <= 1'b0;
    end else if (cmd.query) begin
      res_side <= (cur_head[3:2] == 2'b00) ? get_side(eff, dir_t'(cur_head[1:0])) : UNKNOWN;
      res_unexp <= (get_side(eff, DIR_N) == UNKNOWN) || (get_side(eff, DIR_E) == UNKNOWN) ||
                   (get_side(eff, DIR_S) == UNKNOWN) || (get_side(eff, DIR_W) == UNKNOWN);
    end
    if (cmd.load_out) begin
      side_state <= res_side;
      cell_unexplored <= res_unexp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.load_out) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  a_one_write: assert property (@(posedge clk) disable iff (rst)
    !(cmd.wr_center && cmd.wr_nb) && !(cmd.clear && wr_en))
    else $error("conflicting map updates in one cycle");

  a_load_out_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!result_valid || !result_stall))
    else $error("result register overwritten while held");

  a_load_out_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> result_valid)
    else $error("loaded result not presented");

endmodule

// ===== design/maze_wall_map_core.sv =====
// Top level of the maze wall map: controller and datapath.
// From the accepting edge, a clear or no-op passes through FINISH, a query through
// QUERY and FINISH, and a record through MERGE, the four neighbor states and FINISH;
// FINISH waits while the output is stalled, and input stall drops as the result turns valid.
// Record time is set by one read-modify-write of the map memory per cell
// (the cell, then its four neighbors) through a single read and write port.
// Reset clears all cell valid bits at once, so the map reads as cleared with
// border walls immediately; a clear transaction drops them at its accepting edge.
module maze_wall_map_core import mwm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  logic [OP_W-1:0]   operation,
  input  logic [POS_W-1:0]  pos_x,
  input  logic [POS_W-1:0]  pos_y,
  input  logic [HEAD_W-1:0] heading,
  input  logic              front_right_wall,
  input  logic              front_left_wall,
  input  logic              side_right_wall,
  input  logic              side_left_wall,
  output logic              result_valid,
  input  logic              result_stall,
  output logic [SIDE_W-1:0] side_state,
  output logic              cell_unexplored
);

  cmd_t    cmd;
  status_t status;

  mwm_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .status     (status),
    .cmd        (cmd)
  );

  mwm_datapath u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .operation        (operation),
    .pos_x            (pos_x),
    .pos_y            (pos_y),
    .heading          (heading),
    .front_right_wall (front_right_wall),
    .front_left_wall  (front_left_wall),
    .side_right_wall  (side_right_wall),
    .side_left_wall   (side_left_wall),
    .result_valid     (result_valid),
    .result_stall     (result_stall),
    .side_state       (side_state),
    .cell_unexplored  (cell_unexplored)
  );

endmodule
